// File: rtl/abd_pkg.sv
`default_nettype none
package abd_pkg;

	localparam int AccW     = 25;
	localparam int CoefW    = 8;
	localparam int SampleW  = 16;
	localparam int SumW     = 20;
	localparam int FiltW    = AccW - 6;

	localparam logic [3:0] MaxShift   = 4'd12;
	localparam logic [3:0] LargeShift = 4'd9;
	localparam logic [3:0] MaxFilter  = 4'd4;
	localparam logic [3:0] LastPos    = 4'd15;
	localparam logic [3:0] HeaderPos  = 4'd0;
	localparam logic [3:0] SkipPos    = 4'd1;
	localparam logic signed [AccW-1:0] RoundBias = AccW'(32);

	localparam logic signed [SumW-1:0] SatHi = SumW'(32767);
	localparam logic signed [SumW-1:0] SatLo = -SumW'(32768);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic signed [SampleW-1:0] sample;
		logic                      last_of_byte;
		logic                      block_end;
	} out_item_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_MUL_NEW = 4'b0010,
		ST_MUL_OLD = 4'b0100,
		ST_FINISH  = 4'b1000
	} state_t;

	function automatic logic signed [CoefW-1:0] coef_pos(input logic [2:0] f);
		logic signed [CoefW-1:0] c;
		case (f)
			3'd1:    c = 8'sd60;
			3'd2:    c = 8'sd115;
			3'd3:    c = 8'sd98;
			3'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [CoefW-1:0] coef_neg(input logic [2:0] f);
		logic signed [CoefW-1:0] c;
		case (f)
			3'd2:    c = -8'sd52;
			3'd3:    c = -8'sd55;
			3'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/adpcm_block_decoder_unit.sv
`default_nettype none
// channel | signals                     | payload
// --------+-----------------------------+--------------------------------------
// in      | in_valid, in_ready          | in_item  (data_byte, restart)
// out     | out_valid, out_ready        | out_item (sample, last_of_byte, block_end)
//
// Header and skip bytes are taken in ST_IDLE alone. A data byte is accepted, then
// each sample makes two passes through the shared 16x8 multiply-accumulate, then is
// rounded, added and saturated; no new byte is taken until both samples are done.
// A sample waits in the output register; the next stalls in its finish step while
// that register is full and not taken. Reset clears history, header and position.
module adpcm_block_decoder_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire abd_pkg::in_item_t in_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output abd_pkg::out_item_t  out_item
);
	abd_pkg::state_t state_q;
	logic [3:0] pos_q;
	logic [3:0] shift_q;
	logic [2:0] filt_q;
	logic signed [abd_pkg::SampleW-1:0] newer_q;
	logic signed [abd_pkg::SampleW-1:0] older_q;
	logic [7:0] byte_q;
	logic       nib_sel_q;
	logic       last_blk_q;
	logic       out_valid_q;
	abd_pkg::out_item_t out_q;

	abd_pkg::mac_ctrl_t mac_ctrl;
	logic signed [abd_pkg::SampleW-1:0] mac_a;
	logic signed [abd_pkg::CoefW-1:0]   mac_b;
	logic signed [abd_pkg::AccW-1:0]    acc;

	logic       in_fire;
	logic [3:0] cur_pos;
	logic [3:0] nib;
	logic signed [abd_pkg::SampleW-1:0] nib_word;
	logic signed [abd_pkg::SampleW-1:0] nib_shifted;
	logic signed [abd_pkg::FiltW-1:0]   filt_val;
	logic signed [abd_pkg::SumW-1:0]    sum;
	logic signed [abd_pkg::SampleW-1:0] sat;
	logic       out_free;
	logic       finish_go;

	assign in_ready  = (state_q == abd_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cur_pos   = in_item.restart ? abd_pkg::HeaderPos : pos_q;
	assign out_free  = !out_valid_q || out_ready;
	assign finish_go = (state_q == abd_pkg::ST_FINISH) && out_free;

	always_comb begin
		mac_ctrl.en = 1'b0;
		mac_ctrl.clr = 1'b0;
		mac_a = newer_q;
		mac_b = abd_pkg::coef_pos(filt_q);
		case (state_q)
			abd_pkg::ST_MUL_NEW: begin
				mac_ctrl.en = 1'b1;
				mac_ctrl.clr = 1'b1;
			end
			abd_pkg::ST_MUL_OLD: begin
				mac_ctrl.en = 1'b1;
				mac_a = older_q;
				mac_b = abd_pkg::coef_neg(filt_q);
			end
			default: begin
				mac_ctrl.en = 1'b0;
			end
		endcase
	end

	abd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	assign nib         = nib_sel_q ? byte_q[7:4] : byte_q[3:0];
	assign nib_word    = {nib, 12'b0};
	assign nib_shifted = nib_word >>> shift_q;
	assign filt_val    = acc[abd_pkg::AccW-1:6];
	assign sum         = {{(abd_pkg::SumW-abd_pkg::SampleW){nib_shifted[abd_pkg::SampleW-1]}},
		nib_shifted} + {{(abd_pkg::SumW-abd_pkg::FiltW){filt_val[abd_pkg::FiltW-1]}}, filt_val};

	always_comb begin
		if (sum > abd_pkg::SatHi) begin
			sat = abd_pkg::SatHi[abd_pkg::SampleW-1:0];
		end else if (sum < abd_pkg::SatLo) begin
			sat = abd_pkg::SatLo[abd_pkg::SampleW-1:0];
		end else begin
			sat = sum[abd_pkg::SampleW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abd_pkg::ST_IDLE;
			pos_q       <= '0;
			shift_q     <= '0;
			filt_q      <= '0;
			newer_q     <= '0;
			older_q     <= '0;
			nib_sel_q   <= 1'b0;
			last_blk_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				abd_pkg::ST_IDLE: begin
					if (in_fire) begin
						if (in_item.restart) begin
							newer_q <= '0;
							older_q <= '0;
						end
						pos_q <= cur_pos + 4'd1;
						if (cur_pos == abd_pkg::HeaderPos) begin
							shift_q <= (in_item.data_byte[3:0] > abd_pkg::MaxShift) ?
								abd_pkg::LargeShift : in_item.data_byte[3:0];
							filt_q  <= (in_item.data_byte[7:4] > abd_pkg::MaxFilter) ?
								abd_pkg::MaxFilter[2:0] : in_item.data_byte[6:4];
						end else if (cur_pos != abd_pkg::SkipPos) begin
							byte_q     <= in_item.data_byte;
							last_blk_q <= (cur_pos == abd_pkg::LastPos);
							nib_sel_q  <= 1'b0;
							state_q    <= abd_pkg::ST_MUL_NEW;
						end
					end
				end
				abd_pkg::ST_MUL_NEW: begin
					state_q <= abd_pkg::ST_MUL_OLD;
				end
				abd_pkg::ST_MUL_OLD: begin
					state_q <= abd_pkg::ST_FINISH;
				end
				abd_pkg::ST_FINISH: begin
					if (finish_go) begin
						older_q     <= newer_q;
						newer_q     <= sat;
						nib_sel_q   <= 1'b1;
						state_q     <= nib_sel_q ? abd_pkg::ST_IDLE : abd_pkg::ST_MUL_NEW;
					end
				end
				default: begin
					state_q <= abd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_q.sample       <= sat;
			out_q.last_of_byte <= nib_sel_q;
			out_q.block_end    <= nib_sel_q && last_blk_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule
`default_nettype wire

// File: rtl/abd_mac.sv
`default_nettype none
module abd_mac (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire abd_pkg::mac_ctrl_t                  ctrl,
	input  wire logic signed [abd_pkg::SampleW-1:0]  a,
	input  wire logic signed [abd_pkg::CoefW-1:0]    b,
	output logic signed [abd_pkg::AccW-1:0]          acc
);
	logic signed [abd_pkg::AccW-1:0] acc_q;
	logic signed [abd_pkg::AccW-1:0] prod;
	logic signed [abd_pkg::AccW-1:0] base;

	assign prod = abd_pkg::AccW'(a) * abd_pkg::AccW'(b);
	assign base = ctrl.clr ? abd_pkg::RoundBias : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			acc_q <= base + prod;
		end
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

// File: tb/sv/adpcm_block_decoder_unit_tb.sv
`timescale 1ns / 1ps
module adpcm_block_decoder_unit_tb;

	localparam int CycleLimit = 600000;
	localparam int RandomItems = 700;
	localparam int QuietFrom = 600;
	localparam int PosTap [5] = '{0, 60, 115, 98, 122};
	localparam int NegTap [5] = '{0, 0, -52, -55, -60};

	class sample_scoreboard;
		logic [3:0] byte_pos;
		logic [3:0] shift_amt;
		logic [2:0] filter_sel;
		int newer_s;
		int older_s;
		abd_pkg::out_item_t expected_q[$];
		int errors;

		function new();
			byte_pos = abd_pkg::HeaderPos;
			shift_amt = '0;
			filter_sel = '0;
			newer_s = 0;
			older_s = 0;
			errors = 0;
		endfunction

		function int decode_nibble(logic [3:0] nib);
			int v;
			int s;
			int acc;
			v = int'(nib);
			if (v >= 8)
				v -= 16;
			s = (v * 4096) >>> shift_amt;
			acc = newer_s * PosTap[filter_sel] + older_s * NegTap[filter_sel] + 32;
			s += acc >>> 6;
			if (s > 32767)
				s = 32767;
			else if (s < -32768)
				s = -32768;
			older_s = newer_s;
			newer_s = s;
			return s;
		endfunction

		function void note_input(abd_pkg::in_item_t it);
			logic [3:0] cur;
			abd_pkg::out_item_t e;
			if (it.restart) begin
				newer_s = 0;
				older_s = 0;
				byte_pos = abd_pkg::HeaderPos;
			end
			cur = byte_pos;
			byte_pos = byte_pos + 4'd1;
			if (cur == abd_pkg::HeaderPos) begin
				shift_amt = (it.data_byte[3:0] > abd_pkg::MaxShift) ? abd_pkg::LargeShift
					: it.data_byte[3:0];
				filter_sel = (it.data_byte[7:4] > abd_pkg::MaxFilter) ? 3'(abd_pkg::MaxFilter)
					: it.data_byte[6:4];
			end else if (cur != abd_pkg::SkipPos) begin
				e.sample = 16'(decode_nibble(it.data_byte[3:0]));
				e.last_of_byte = 1'b0;
				e.block_end = 1'b0;
				expected_q.push_back(e);
				e.sample = 16'(decode_nibble(it.data_byte[7:4]));
				e.last_of_byte = 1'b1;
				e.block_end = (cur == abd_pkg::LastPos);
				expected_q.push_back(e);
			end
		endfunction

		function void check_result(abd_pkg::out_item_t got);
			abd_pkg::out_item_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected sample %0d", $signed(got.sample));
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.sample !== e.sample) begin
				$error("sample: expected %0d, actual %0d", $signed(e.sample), $signed(got.sample));
				errors++;
			end
			if (got.last_of_byte !== e.last_of_byte) begin
				$error("last_of_byte: expected %0b, actual %0b", e.last_of_byte,
					got.last_of_byte);
				errors++;
			end
			if (got.block_end !== e.block_end) begin
				$error("block_end: expected %0b, actual %0b", e.block_end, got.block_end);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	abd_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	abd_pkg::out_item_t out_item;

	sample_scoreboard sb;
	int items_sent;
	bit quiet;
	int cycle_count;

	adpcm_block_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(in_item);
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("adpcm_block_decoder_unit_tb failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic rst);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_item.data_byte <= b;
		in_item.restart <= rst;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_data();
		logic [7:0] edges [8] = '{8'h77, 8'h88, 8'h07, 8'h70, 8'h80, 8'h08, 8'hFF, 8'h00};
		if ($urandom_range(0, 9) < 3)
			return edges[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_random_block();
		logic [3:0] sh;
		logic [3:0] f;
		sh = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
		f = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4));
		send_byte({f, sh}, $urandom_range(0, 3) == 0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		for (int k = 2; k < 16; k++)
			send_byte(pick_data(), $urandom_range(0, 49) == 0);
	endtask

	initial begin
		sb = new();
		items_sent = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// large shift, large filter, nibble extremes
		send_byte(8'hFD, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		// max shift, no filter
		send_byte(8'h0C, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		// drive into both saturation limits
		send_byte(8'h40, 1'b1);
		send_byte(8'hFF, 1'b0);
		repeat (6) send_byte(8'h77, 1'b0);
		repeat (4) send_byte(8'h88, 1'b0);

		items_sent = 0;
		send_byte(8'h3F, 1'b1);
		while (items_sent < RandomItems) begin
			if (items_sent >= QuietFrom)
				quiet = 1'b1;
			send_random_block();
		end
		quiet = 1'b1;
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("adpcm_block_decoder_unit_tb passed");
		end else begin
			$display("adpcm_block_decoder_unit_tb failed");
		end
		$finish;
	end

endmodule
